// ===== hdl/glrhs_pkg.sv =====
// ----------------------------------------------------------------------------
// glrhs_pkg
// Shared types, constants and helpers of the Ginzburg-Landau stencil unit.
// ----------------------------------------------------------------------------
package glrhs_pkg;

   // register map, word index of each register
   localparam int unsigned REG_BOUNDARY_MODE = 0;
   localparam int unsigned REG_INV_DX_SQ     = 1;

   // boundary modes
   localparam logic MODE_DIRICHLET = 1'b0;
   localparam logic MODE_PERIODIC  = 1'b1;

   // grid position codes
   localparam logic [1:0] POS_INTERIOR = 2'd0;
   localparam logic [1:0] POS_FIRST    = 2'd1;
   localparam logic [1:0] POS_LAST     = 2'd2;

   // reset values
   localparam logic [15:0] INV_DX_SQ_RESET = 16'd256;

   // 0.1 as 1677722 / 2^24
   localparam logic signed [22:0] TENTH_Q24 = 23'sd1677722;

   // output range, Q11.12
   localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] OUT_MIN = 24'sh800000;

   // accumulator width at scale 2^-36
   localparam int unsigned ACC_W = 54;

   typedef struct packed {
      logic        boundary_mode;
      logic [15:0] inv_dx_squared;
   } cfg_type;

   typedef struct packed {
      logic signed [23:0] value;
      logic               clipped;
   } sat_type;

   // round half up from scale 2^-36 to 2^-12, then clip to 24 bits
   function automatic sat_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]    biased;
      logic signed [ACC_W-24:0] shifted;
      sat_type                  res;
      biased  = (ACC_W+1)'(acc) + (ACC_W+1)'(64'sd8388608);
      shifted = biased[ACC_W:24];
      if (shifted > (ACC_W-23)'(OUT_MAX)) begin
         res.value   = OUT_MAX;
         res.clipped = 1'b1;
      end else if (shifted < (ACC_W-23)'(OUT_MIN)) begin
         res.value   = OUT_MIN;
         res.clipped = 1'b1;
      end else begin
         res.value   = shifted[23:0];
         res.clipped = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== hdl/ginzburg_landau_rhs_stencil_unit.sv =====
// ----------------------------------------------------------------------------
// ginzburg_landau_rhs_stencil_unit
// Right-hand side of the complex Ginzburg-Landau equation for one grid point:
// i*lap - (1+i)*|psi|^2*psi + 0.1*psi, with a three-point laplacian.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  neighbors, field, grid position
//   rsp_      out        rsp_valid/rsp_ready  rate_re, rate_im, saturated
//   config    in         psel/penable/pready  boundary_mode, inv_dx_squared
//
// One transaction per cycle sustained while rsp_ready is high; the datapath
// has five register stages (the cubic product m*(fr +/- fi) sits in a stage
// of its own).
// Reset clears the stage valid bits and restores the register defaults.
// A stall on the result side fills empty stages first; req_ready drops only
// when every stage holds an item.
// ----------------------------------------------------------------------------
module ginzburg_landau_rhs_stencil_unit (
   input  logic               clock,
   input  logic               reset,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_left_re,
   input  logic signed [15:0] req_left_im,
   input  logic signed [15:0] req_center_re,
   input  logic signed [15:0] req_center_im,
   input  logic signed [15:0] req_right_re,
   input  logic signed [15:0] req_right_im,
   input  logic signed [15:0] req_field_re,
   input  logic signed [15:0] req_field_im,
   input  logic [1:0]         req_grid_position,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_rate_re,
   output logic signed [23:0] rsp_rate_im,
   output logic               rsp_saturated
);
   import glrhs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [0:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2:2];
   assign wr_en   = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            1'(REG_BOUNDARY_MODE): cfg_in.boundary_mode  = pwdata[0];
            1'(REG_INV_DX_SQ):     cfg_in.inv_dx_squared = pwdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boundary_mode  <= MODE_DIRICHLET;
         cfg_ff.inv_dx_squared <= INV_DX_SQ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      case (reg_sel)
         1'(REG_BOUNDARY_MODE): prdata = {31'd0, cfg_ff.boundary_mode};
         1'(REG_INV_DX_SQ):     prdata = {16'd0, cfg_ff.inv_dx_squared};
         default:               prdata = 32'd0;
      endcase
   end

   // datapath
   glrhs_pipe u_pipe (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_re       (req_left_re),
      .req_left_im       (req_left_im),
      .req_center_re     (req_center_re),
      .req_center_im     (req_center_im),
      .req_right_re      (req_right_re),
      .req_right_im      (req_right_im),
      .req_field_re      (req_field_re),
      .req_field_im      (req_field_im),
      .req_grid_position (req_grid_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rate_re       (rsp_rate_re),
      .rsp_rate_im       (rsp_rate_im),
      .rsp_saturated     (rsp_saturated)
   );

   // defaults after reset
   a_reset_defaults: assert property (@(posedge clock)
      $past(reset) |-> (cfg_ff.boundary_mode == MODE_DIRICHLET) &&
                       (cfg_ff.inv_dx_squared == INV_DX_SQ_RESET))
      else $error("configuration not at defaults after reset");

   // a write to the scale register lands
   a_scale_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && (reg_sel == 1'(REG_INV_DX_SQ)) |=>
         cfg_ff.inv_dx_squared == $past(pwdata[15:0]))
      else $error("scale register write lost");

   // a write to the mode register lands
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && (reg_sel == 1'(REG_BOUNDARY_MODE)) |=>
         cfg_ff.boundary_mode == $past(pwdata[0]))
      else $error("mode register write lost");

endmodule

// ===== hdl/glrhs_pipe.sv =====
// ----------------------------------------------------------------------------
// glrhs_pipe
// Five-stage datapath for one stencil point per cycle while rsp_ready is high,
// with per-stage valid bits and bubble-collapsing flow control.
// ----------------------------------------------------------------------------
module glrhs_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  glrhs_pkg::cfg_type     cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_left_re,
   input  logic signed [15:0]     req_left_im,
   input  logic signed [15:0]     req_center_re,
   input  logic signed [15:0]     req_center_im,
   input  logic signed [15:0]     req_right_re,
   input  logic signed [15:0]     req_right_im,
   input  logic signed [15:0]     req_field_re,
   input  logic signed [15:0]     req_field_im,
   input  logic [1:0]             req_grid_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [23:0]     rsp_rate_re,
   output logic signed [23:0]     rsp_rate_im,
   output logic                   rsp_saturated
);
   import glrhs_pkg::*;

   // stage valid bits and advance enables
   logic [4:0] valid_ff, valid_in;
   logic [4:0] adv;

   // stage 1: differences, squares, linear term
   logic signed [17:0] d_re_ff, d_re_in, d_im_ff, d_im_in;
   logic signed [31:0] sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic signed [16:0] psum_1_ff, psum_1_in, pdif_1_ff, pdif_1_in;
   logic signed [37:0] lin_re_1_ff, lin_re_1_in, lin_im_1_ff, lin_im_1_in;

   // stage 2: magnitude and scaled laplacian
   logic signed [32:0] mag_ff, mag_in;
   logic signed [34:0] lap_re_2_ff, lap_re_2_in, lap_im_2_ff, lap_im_2_in;
   logic signed [16:0] psum_2_ff, pdif_2_ff;
   logic signed [37:0] lin_re_2_ff, lin_im_2_ff;

   // stage 3: cubic products
   logic signed [49:0] nl_re_ff, nl_re_in, nl_im_ff, nl_im_in;
   logic signed [34:0] lap_re_3_ff, lap_im_3_ff;
   logic signed [37:0] lin_re_3_ff, lin_im_3_ff;

   // stage 4: exact sums
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   // stage 5: output register
   sat_type sat_re, sat_im;
   logic signed [23:0] out_re_ff, out_im_ff;
   logic               out_sat_ff;

   // neighbor masking
   logic signed [15:0] left_re, left_im, right_re, right_im;
   logic               drop_left, drop_right;
   logic signed [16:0] kval;

   // flow control: a stage moves when it is empty or the next one moves
   always_comb begin
      adv[4] = !valid_ff[4] || rsp_ready;
      for (int i = 3; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < 5; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign req_ready = adv[0];

   // dirichlet boundary zeroes the missing neighbor
   always_comb begin
      drop_left  = (cfg.boundary_mode == MODE_DIRICHLET) && (req_grid_position == POS_FIRST);
      drop_right = (cfg.boundary_mode == MODE_DIRICHLET) && (req_grid_position == POS_LAST);
      left_re    = drop_left  ? 16'sd0 : req_left_re;
      left_im    = drop_left  ? 16'sd0 : req_left_im;
      right_re   = drop_right ? 16'sd0 : req_right_re;
      right_im   = drop_right ? 16'sd0 : req_right_im;
   end

   // stage 1 logic
   always_comb begin
      d_re_in     = 18'(left_re) - (18'(req_center_re) <<< 1) + 18'(right_re);
      d_im_in     = 18'(left_im) - (18'(req_center_im) <<< 1) + 18'(right_im);
      sq_re_in    = req_field_re * req_field_re;
      sq_im_in    = req_field_im * req_field_im;
      psum_1_in   = 17'(req_field_re) + 17'(req_field_im);
      pdif_1_in   = 17'(req_field_re) - 17'(req_field_im);
      lin_re_1_in = req_field_re * TENTH_Q24;
      lin_im_1_in = req_field_im * TENTH_Q24;
   end

   // stage 2 logic
   assign kval = $signed({1'b0, cfg.inv_dx_squared});
   always_comb begin
      mag_in      = 33'(sq_re_ff) + 33'(sq_im_ff);
      lap_re_2_in = d_re_ff * kval;
      lap_im_2_in = d_im_ff * kval;
   end

   // stage 3 logic
   always_comb begin
      nl_re_in = mag_ff * pdif_2_ff;
      nl_im_in = mag_ff * psum_2_ff;
   end

   // stage 4 logic: rate_re = -lap_im - m*(fr-fi) + 0.1*fr, rate_im likewise
   always_comb begin
      acc_re_in = - ACC_W'($signed({lap_im_3_ff, 16'h0000})) - ACC_W'(nl_re_ff)
                  + ACC_W'(lin_re_3_ff);
      acc_im_in =   ACC_W'($signed({lap_re_3_ff, 16'h0000})) - ACC_W'(nl_im_ff)
                  + ACC_W'(lin_im_3_ff);
   end

   // stage 5 logic
   always_comb begin
      sat_re = round_sat(acc_re_ff);
      sat_im = round_sat(acc_im_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d_re_ff     <= d_re_in;
         d_im_ff     <= d_im_in;
         sq_re_ff    <= sq_re_in;
         sq_im_ff    <= sq_im_in;
         psum_1_ff   <= psum_1_in;
         pdif_1_ff   <= pdif_1_in;
         lin_re_1_ff <= lin_re_1_in;
         lin_im_1_ff <= lin_im_1_in;
      end
      if (adv[1]) begin
         mag_ff      <= mag_in;
         lap_re_2_ff <= lap_re_2_in;
         lap_im_2_ff <= lap_im_2_in;
         psum_2_ff   <= psum_1_ff;
         pdif_2_ff   <= pdif_1_ff;
         lin_re_2_ff <= lin_re_1_ff;
         lin_im_2_ff <= lin_im_1_ff;
      end
      if (adv[2]) begin
         nl_re_ff    <= nl_re_in;
         nl_im_ff    <= nl_im_in;
         lap_re_3_ff <= lap_re_2_ff;
         lap_im_3_ff <= lap_im_2_ff;
         lin_re_3_ff <= lin_re_2_ff;
         lin_im_3_ff <= lin_im_2_ff;
      end
      if (adv[3]) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      if (adv[4]) begin
         out_re_ff  <= sat_re.value;
         out_im_ff  <= sat_im.value;
         out_sat_ff <= sat_re.clipped || sat_im.clipped;
      end
   end

   assign rsp_valid     = valid_ff[4];
   assign rsp_rate_re   = out_re_ff;
   assign rsp_rate_im   = out_im_ff;
   assign rsp_saturated = out_sat_ff;

   // an accepted transaction always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted transaction lost at stage 1");

   // a valid stage that may advance hands its item on
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && adv[2] |=> valid_ff[2])
      else $error("item dropped between stages 2 and 3");

   // the flag only comes with a clipped value
   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_rate_re == OUT_MAX) || (rsp_rate_re == OUT_MIN) ||
         (rsp_rate_im == OUT_MAX) || (rsp_rate_im == OUT_MIN))
      else $error("saturated flag without clipped value");

endmodule

// ===== dv/glrhs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glrhs_checker
// Passive checker for the Ginzburg-Landau stencil unit: tracks register
// writes, predicts the rate of every accepted point and compares it field by
// field with the results in order of arrival.
// ----------------------------------------------------------------------------
module glrhs_checker (
   input  logic               clock,
   input  logic               reset,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   // request channel
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_left_re,
   input  logic signed [15:0] req_left_im,
   input  logic signed [15:0] req_center_re,
   input  logic signed [15:0] req_center_im,
   input  logic signed [15:0] req_right_re,
   input  logic signed [15:0] req_right_im,
   input  logic signed [15:0] req_field_re,
   input  logic signed [15:0] req_field_im,
   input  logic [1:0]         req_grid_position,
   // response channel
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [23:0] rsp_rate_re,
   input  logic signed [23:0] rsp_rate_im,
   input  logic               rsp_saturated,
   // status to the top
   output int                 fail_count,
   output int                 pending
);
   import glrhs_pkg::*;

   typedef struct packed {
      logic signed [15:0] left_re;
      logic signed [15:0] left_im;
      logic signed [15:0] center_re;
      logic signed [15:0] center_im;
      logic signed [15:0] right_re;
      logic signed [15:0] right_im;
      logic signed [15:0] field_re;
      logic signed [15:0] field_im;
      logic [1:0]         grid_position;
   } stencil_point_type;

   typedef struct packed {
      logic signed [23:0] rate_re;
      logic signed [23:0] rate_im;
      logic               saturated;
   } rate_type;

   cfg_type  cfg_copy;
   rate_type expected_rates[$];

   // scale 2^-36 down to Q11.12, half rounds up, then clip to 24 bits
   function automatic logic signed [23:0] round_clip(input longint acc, inout logic clipped);
      longint q;
      q = (acc + 64'sd8388608) >>> 24;
      if (q > longint'(OUT_MAX)) begin
         clipped = 1'b1;
         return OUT_MAX;
      end
      if (q < longint'(OUT_MIN)) begin
         clipped = 1'b1;
         return OUT_MIN;
      end
      return q[23:0];
   endfunction

   // rate = i*lap - (1+i)*|p|^2*p + 0.1*p, summed exactly at scale 2^-36
   function automatic rate_type predict_rate(input cfg_type cfg, input stencil_point_type pt);
      longint   lr, li, cr, ci, rr, ri, fr, fi;
      longint   k, tenth, lap_re, lap_im, mag_sq, acc_re, acc_im;
      logic     clipped;
      rate_type r;
      lr = pt.left_re;
      li = pt.left_im;
      cr = pt.center_re;
      ci = pt.center_im;
      rr = pt.right_re;
      ri = pt.right_im;
      fr = pt.field_re;
      fi = pt.field_im;
      // zero boundary drops the missing neighbor; position 3 stays interior
      if (cfg.boundary_mode == MODE_DIRICHLET) begin
         if (pt.grid_position == POS_FIRST) begin
            lr = 0;
            li = 0;
         end
         if (pt.grid_position == POS_LAST) begin
            rr = 0;
            ri = 0;
         end
      end
      k      = longint'(cfg.inv_dx_squared);
      tenth  = longint'(TENTH_Q24);
      lap_re = (lr - 2 * cr + rr) * k * 65536;
      lap_im = (li - 2 * ci + ri) * k * 65536;
      mag_sq = fr * fr + fi * fi;
      acc_re = -lap_im - mag_sq * (fr - fi) + fr * tenth;
      acc_im =  lap_re - mag_sq * (fr + fi) + fi * tenth;
      clipped   = 1'b0;
      r.rate_re = round_clip(acc_re, clipped);
      r.rate_im = round_clip(acc_im, clipped);
      r.saturated = clipped;
      return r;
   endfunction

   // register tracking, prediction on accepted requests, comparison on results
   always @(posedge clock) begin
      stencil_point_type pt;
      rate_type          want;
      if (reset) begin
         cfg_copy.boundary_mode  = MODE_DIRICHLET;
         cfg_copy.inv_dx_squared = INV_DX_SQ_RESET;
         expected_rates.delete();
         fail_count = 0;
         pending    = 0;
      end else begin
         // register write transaction
         if (psel && penable && pwrite && pready) begin
            if (int'(paddr >> 2) == REG_BOUNDARY_MODE)
               cfg_copy.boundary_mode = pwdata[0];
            else if (int'(paddr >> 2) == REG_INV_DX_SQ)
               cfg_copy.inv_dx_squared = pwdata[15:0];
         end
         // result transaction against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_rates.size() == 0) begin
               $error("result transaction with nothing expected: rate_re %0d rate_im %0d",
                      rsp_rate_re, rsp_rate_im);
               fail_count++;
            end else begin
               want = expected_rates.pop_front();
               if (rsp_rate_re !== want.rate_re) begin
                  $error("rate_re mismatch: expected %0d actual %0d", want.rate_re, rsp_rate_re);
                  fail_count++;
               end
               if (rsp_rate_im !== want.rate_im) begin
                  $error("rate_im mismatch: expected %0d actual %0d", want.rate_im, rsp_rate_im);
                  fail_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %0d actual %0d",
                         want.saturated, rsp_saturated);
                  fail_count++;
               end
            end
         end
         // request transaction
         if (req_valid && req_ready) begin
            pt.left_re       = req_left_re;
            pt.left_im       = req_left_im;
            pt.center_re     = req_center_re;
            pt.center_im     = req_center_im;
            pt.right_re      = req_right_re;
            pt.right_im      = req_right_im;
            pt.field_re      = req_field_re;
            pt.field_im      = req_field_im;
            pt.grid_position = req_grid_position;
            expected_rates.insert(expected_rates.size(), predict_rate(cfg_copy, pt));
         end
         pending = expected_rates.size();
      end
   end

endmodule

// ===== dv/tb_ginzburg_landau_rhs_stencil_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ginzburg_landau_rhs_stencil_unit
// Regression for the stencil unit: directed corner points, then random points
// over several boundary and grid-spacing settings with gaps on both channels
// and long result-side stalls. Checking is done by glrhs_checker.
// ----------------------------------------------------------------------------
module tb_ginzburg_landau_rhs_stencil_unit;
   import glrhs_pkg::*;

   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 64;
   localparam int PHASE_COUNT  = 6;

   typedef struct {
      logic signed [15:0] left_re;
      logic signed [15:0] left_im;
      logic signed [15:0] center_re;
      logic signed [15:0] center_im;
      logic signed [15:0] right_re;
      logic signed [15:0] right_im;
      logic signed [15:0] field_re;
      logic signed [15:0] field_im;
      logic [1:0]         grid_position;
   } stencil_point_type;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_left_re;
   logic signed [15:0] req_left_im;
   logic signed [15:0] req_center_re;
   logic signed [15:0] req_center_im;
   logic signed [15:0] req_right_re;
   logic signed [15:0] req_right_im;
   logic signed [15:0] req_field_re;
   logic signed [15:0] req_field_im;
   logic [1:0]         req_grid_position;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [23:0] rsp_rate_re;
   logic signed [23:0] rsp_rate_im;
   logic               rsp_saturated;

   int fail_count;
   int pending;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int hold_served;
   int hold_left;

   ginzburg_landau_rhs_stencil_unit dut (.*);

   glrhs_checker u_checker (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ginzburg_landau_rhs_stencil_unit regression: fail");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready   = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic write_reg(input int unsigned index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(index * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // both registers, with junk in the bits above each register
   task automatic set_config(input logic mode, input logic [15:0] inv_dx_sq);
      write_reg(REG_BOUNDARY_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(mode));
      write_reg(REG_INV_DX_SQ, ($urandom & 32'hFFFF_0000) | 32'(inv_dx_sq));
   endtask

   // offer one point, keep valid up across back-to-back transactions
   task automatic send_point(input stencil_point_type pt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_left_re       <= pt.left_re;
      req_left_im       <= pt.left_im;
      req_center_re     <= pt.center_re;
      req_center_im     <= pt.center_im;
      req_right_re      <= pt.right_re;
      req_right_im      <= pt.right_im;
      req_field_re      <= pt.field_re;
      req_field_im      <= pt.field_im;
      req_grid_position <= pt.grid_position;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic stencil_point_type make_point(
      input logic signed [15:0] lr, input logic signed [15:0] li,
      input logic signed [15:0] cr, input logic signed [15:0] ci,
      input logic signed [15:0] rr, input logic signed [15:0] ri,
      input logic signed [15:0] fr, input logic signed [15:0] fi,
      input logic [1:0] pos);
      stencil_point_type pt;
      pt.left_re       = lr;
      pt.left_im       = li;
      pt.center_re     = cr;
      pt.center_im     = ci;
      pt.right_re      = rr;
      pt.right_im      = ri;
      pt.field_re      = fr;
      pt.field_im      = fi;
      pt.grid_position = pos;
      return pt;
   endfunction

   // mix of full-range values, values near unity and the corners
   function automatic logic signed [15:0] pick_sample();
      logic signed [15:0] v;
      case ($urandom_range(3))
         0, 1: v = 16'($urandom);
         2: begin
            v = 16'($urandom_range(8191));
            v = v - 16'sd4096;
         end
         default: begin
            case ($urandom_range(3))
               0:       v = 16'sh7FFF;
               1:       v = 16'sh8000;
               2:       v = 16'sh0000;
               default: v = 16'shFFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic stencil_point_type random_point();
      return make_point(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                        pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                        2'($urandom_range(3)));
   endfunction

   // stimulus
   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_valid         = 1'b0;
      req_left_re       = '0;
      req_left_im       = '0;
      req_center_re     = '0;
      req_center_im     = '0;
      req_right_re      = '0;
      req_right_im      = '0;
      req_field_re      = '0;
      req_field_im      = '0;
      req_grid_position = POS_INTERIOR;
      hold_requests     = 0;
      send_idle_pct     = 34;
      recv_idle_pct     = 48;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: zero boundary, unit grid spacing
      send_point(make_point(0, 0, 0, 0, 0, 0, 0, 0, POS_INTERIOR));
      send_point(make_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                            16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, POS_INTERIOR));
      send_point(make_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, POS_INTERIOR));
      // large cubic terms
      send_point(make_point(0, 0, 0, 0, 0, 0, 16'sh7FFF, 0, POS_INTERIOR));
      send_point(make_point(0, 0, 0, 0, 0, 0, 16'sh8000, 16'sh8000, POS_INTERIOR));
      // unit field, then rounding near zero
      send_point(make_point(0, 0, 0, 0, 0, 0, 16'sd4096, 0, POS_INTERIOR));
      send_point(make_point(0, 0, 0, 0, 0, 0, 16'shFFFF, 16'shFFFF, POS_INTERIOR));
      send_point(make_point(0, 0, 0, 0, 0, 0, 16'sd1, 16'sd0, POS_INTERIOR));
      // largest laplacian
      send_point(make_point(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                            16'sh7FFF, 16'sh7FFF, 0, 0, POS_INTERIOR));
      // missing neighbor ignored at the ends, unused code acts as interior
      send_point(make_point(16'sh7FFF, 16'sh8000, 16'sd100, 16'sd200,
                            16'sd300, 16'sd400, 16'sd500, 16'sd600, POS_FIRST));
      send_point(make_point(16'sd300, 16'sd400, 16'sd100, 16'sd200,
                            16'sh8000, 16'sh7FFF, 16'sd500, 16'sd600, POS_LAST));
      send_point(make_point(16'sd300, 16'sd400, 16'sd100, 16'sd200,
                            16'sh8000, 16'sh7FFF, 16'sd500, 16'sd600, 2'd3));
      wait_drained();

      // wrap boundary, steepest grid spacing
      set_config(MODE_PERIODIC, 16'hFFFF);
      send_point(make_point(16'sh7FFF, 16'sh8000, 16'sd100, 16'sd200,
                            16'sd300, 16'sd400, 16'sd500, 16'sd600, POS_FIRST));
      send_point(make_point(16'sd300, 16'sd400, 16'sd100, 16'sd200,
                            16'sh8000, 16'sh7FFF, 16'sd500, 16'sd600, POS_LAST));
      send_point(make_point(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                            16'sh7FFF, 16'sh8000, 0, 0, POS_INTERIOR));
      send_point(make_point(16'sd1, 16'sd2, 16'sd3, 16'sd4,
                            16'sd5, 16'sd6, 16'sd7, 16'sd8, 2'd3));
      send_point(make_point(16'sd1, 16'shFFFF, 0, 0, 0, 16'sd1, 16'sd4096, 16'sh8000,
                            POS_FIRST));
      wait_drained();

      // random phases over several settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       set_config(MODE_PERIODIC, 16'h0000);
            1:       set_config(MODE_DIRICHLET, 16'hFFFF);
            2:       set_config(MODE_PERIODIC, INV_DX_SQ_RESET);
            3:       set_config(MODE_DIRICHLET, 16'h0001);
            4:       set_config(MODE_PERIODIC, 16'($urandom));
            default: set_config(MODE_DIRICHLET, 16'($urandom));
         endcase
         send_idle_pct = (phase < 2) ? 34 : (phase < 4) ? 48 : 0;
         recv_idle_pct <= (phase < 2) ? 48 : (phase < 4) ? 34 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long result-side stall while points keep coming
            if ((phase == 1 || phase == 4) && n == 8)
               hold_requests <= hold_requests + 1;
            send_point(random_point());
         end
         wait_drained();
      end

      if (fail_count == 0 && pending == 0)
         $display("ginzburg_landau_rhs_stencil_unit regression: pass");
      else
         $display("ginzburg_landau_rhs_stencil_unit regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/glrhs_pkg.sv
hdl/glrhs_pipe.sv
hdl/ginzburg_landau_rhs_stencil_unit.sv
dv/glrhs_checker.sv
dv/tb_ginzburg_landau_rhs_stencil_unit.sv
